// ===== hw/rtl/sadp_pkg.sv =====
package sadp_pkg;

  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] BOUND_LOWER = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd2;

  typedef struct packed {
    logic        [63:0] key;
    logic        [15:0] move;
    logic signed [15:0] eval;
    logic signed [7:0]  depth;
    logic        [1:0]  bound;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    key:   64'd0,
    move:  16'd0,
    eval:  16'sd0,
    depth: -8'sd1,
    bound: BOUND_LOWER
  };

endpackage

// ===== hw/rtl/set_assoc_depth_pref_table.sv =====
// Set-associative table of search results with depth-preferred replacement.
// Each set of WAYS entries sits in one row of a single-port-read, single-port-write
// memory with a registered read. A probe or store reads the row of its set, picks
// the first way with an equal key (else the first way of least depth) and, for a
// store, writes the row back once the output register is free, if replacement allows.
// When SETS is a power of two the set is the low key bits. Otherwise a remainder unit
// folds in 4 key bits per cycle. A clear rewrites one row per cycle and then gives a
// result beat. After reset the same clearing pass runs over all SETS rows, during
// which no item is accepted. The next item is taken while a finished result still
// waits at the output register.
module set_assoc_depth_pref_table
  import sadp_pkg::*;
#(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [63:0]        key_i,
  input  logic [15:0]        move_i,
  input  logic signed [15:0] eval_i,
  input  logic signed [7:0]  depth_i,
  input  logic [1:0]         bound_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [1:0]         way_o,
  output logic [15:0]        move_out_o,
  output logic signed [15:0] eval_out_o,
  output logic signed [7:0]  depth_out_o,
  output logic [1:0]         bound_out_o,
  output logic               written_o
);

  localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NP        = 1 << WAY_IW;
  localparam bit          POW2      = ((SETS & (SETS - 1)) == 0);
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = 64 / MOD_BITS;
  localparam int unsigned MCNT_W    = $clog2(MOD_STEPS);

  localparam logic [SET_W:0]    SETS_X    = SETS[SET_W:0];
  localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(SETS - 1);
  localparam logic [MCNT_W-1:0] LAST_STEP = MCNT_W'(MOD_STEPS - 1);

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_EVAL,
    ST_CLEAR,
    ST_CRESP
  } state_e;

  state_e              state_q;
  logic [SET_W-1:0]    clr_cnt_q;
  logic                clr_resp_q;
  logic [MCNT_W-1:0]   mod_cnt_q;
  logic [SET_W-1:0]    set_q;

  logic                out_valid_q;
  logic                hit_q;
  logic [1:0]          way_q;
  logic [15:0]         move_out_q;
  logic signed [15:0]  eval_out_q;
  logic signed [7:0]   depth_out_q;
  logic [1:0]          bound_out_q;
  logic                written_q;

  logic                store_q;
  logic [63:0]         key_q;
  logic [15:0]         move_q;
  logic signed [15:0]  eval_q;
  logic signed [7:0]   depth_q;
  logic [1:0]          bound_q;
  logic [63:0]         key_sh_q;
  logic [SET_W-1:0]    rem_q;
  logic [SET_W-1:0]    rem_d;
  logic [SET_W:0]      rem_t;

  row_t                tbl_mem [SETS];
  row_t                rd_row_q;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                mem_re;
  logic [SET_W-1:0]    mem_raddr;
  logic                mem_we;
  logic [SET_W-1:0]    mem_waddr;
  row_t                mem_wdata;

  logic signed [7:0]   md [NP];
  logic [WAY_IW-1:0]   mi [NP];
  logic                hit_c;
  logic [WAY_IW-1:0]   hit_w;
  logic [WAY_IW-1:0]   pick;
  logic [WAY_IW+1:0]   pick_x;
  entry_t              sel;
  logic                old_exact;
  logic                new_exact;
  logic                wr_en;
  row_t                new_row;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = ((state_q == ST_EVAL) || (state_q == ST_CRESP)) && out_free;

  always_comb begin
    rem_d = rem_q;
    rem_t = '0;
    for (int b = 0; b < MOD_BITS; b++) begin
      rem_t = {rem_d, key_sh_q[63 - b]};
      if (rem_t >= SETS_X) begin
        rem_t = rem_t - SETS_X;
      end
      rem_d = rem_t[SET_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      md[i] = 8'sd127;
      mi[i] = '0;
    end
    for (int i = 0; i < WAYS; i++) begin
      md[i] = rd_row_q[i].depth;
      mi[i] = WAY_IW'(i);
    end
    for (int s = 1; s < NP; s = s * 2) begin
      for (int i = 0; i + s < NP; i = i + 2 * s) begin
        if (md[i + s] < md[i]) begin
          md[i] = md[i + s];
          mi[i] = mi[i + s];
        end
      end
    end
  end

  always_comb begin
    hit_c = 1'b0;
    hit_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row_q[w].key == key_q) begin
        hit_c = 1'b1;
        hit_w = WAY_IW'(w);
      end
    end
  end

  always_comb begin
    pick      = hit_c ? hit_w : mi[0];
    pick_x    = {2'b00, pick};
    sel       = rd_row_q[pick];
    old_exact = (sel.bound == BOUND_EXACT);
    new_exact = (bound_q == BOUND_EXACT);
    wr_en     = store_q && !(old_exact && !new_exact) &&
                ((!old_exact && new_exact) || (sel.depth < depth_q));
    new_row       = rd_row_q;
    new_row[pick] = '{key: key_q, move: move_q, eval: eval_q, depth: depth_q,
                      bound: bound_q};
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = key_i[SET_W-1:0];
    if (in_accept && (mode_i != MODE_CLEAR) && POW2) begin
      mem_re = 1'b1;
    end else if ((state_q == ST_MOD) && (mod_cnt_q == LAST_STEP)) begin
      mem_re    = 1'b1;
      mem_raddr = rem_d;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = new_row;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = {WAYS{RESET_ENTRY}};
    end else if ((state_q == ST_EVAL) && out_free && wr_en) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= tbl_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      store_q  <= (mode_i == MODE_STORE);
      key_q    <= key_i;
      move_q   <= move_i;
      eval_q   <= eval_i;
      depth_q  <= depth_i;
      bound_q  <= bound_i;
      key_sh_q <= key_i;
      rem_q    <= '0;
    end else if (state_q == ST_MOD) begin
      key_sh_q <= {key_sh_q[63-MOD_BITS:0], {MOD_BITS{1'b0}}};
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_resp_q  <= 1'b0;
      mod_cnt_q   <= '0;
      set_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      way_q       <= '0;
      move_out_q  <= '0;
      eval_out_q  <= '0;
      depth_out_q <= '0;
      bound_out_q <= '0;
      written_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (mode_i == MODE_CLEAR) begin
              state_q    <= ST_CLEAR;
              clr_cnt_q  <= '0;
              clr_resp_q <= 1'b1;
            end else if (POW2) begin
              state_q <= ST_EVAL;
              set_q   <= key_i[SET_W-1:0];
            end else begin
              state_q   <= ST_MOD;
              mod_cnt_q <= '0;
            end
          end
        end
        ST_MOD: begin
          mod_cnt_q <= mod_cnt_q + 1'b1;
          if (mod_cnt_q == LAST_STEP) begin
            state_q <= ST_EVAL;
            set_q   <= rem_d;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            hit_q       <= hit_c;
            way_q       <= pick_x[1:0];
            move_out_q  <= sel.move;
            eval_out_q  <= sel.eval;
            depth_out_q <= sel.depth;
            bound_out_q <= sel.bound;
            written_q   <= wr_en;
            state_q     <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == LAST_SET) begin
            state_q <= clr_resp_q ? ST_CRESP : ST_IDLE;
          end
        end
        ST_CRESP: begin
          if (out_free) begin
            hit_q       <= 1'b0;
            way_q       <= '0;
            move_out_q  <= '0;
            eval_out_q  <= '0;
            depth_out_q <= '0;
            bound_out_q <= '0;
            written_q   <= 1'b0;
            clr_resp_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_o       = way_q;
  assign move_out_o  = move_out_q;
  assign eval_out_o  = eval_out_q;
  assign depth_out_o = depth_out_q;
  assign bound_out_o = bound_out_q;
  assign written_o   = written_q;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table read and write issued together");

  a_store_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == ST_EVAL)) |-> store_q)
    else $error("table written back by a non-store beat");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && (clr_cnt_q != LAST_SET)) |=>
      ((state_q == ST_CLEAR) && (clr_cnt_q == $past(clr_cnt_q) + 1'b1)))
    else $error("clear sweep skipped or left early");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (($past(state_q) == ST_EVAL) || ($past(state_q) == ST_CRESP)))
    else $error("result beat raised outside a result state");
`endif

endmodule
